@@ rtl/ffh_pkg.sv @@
`timescale 1ns / 1ps
// ffh_pkg: item types, codes and fixed constants of the first-fit heap allocator
// depends on nothing; imported by first_fit_heap_allocator_unit and its bench
package ffh_pkg;

  localparam int PTR_W     = 10;
  localparam int PTR_LIMIT = 1024;

  typedef enum logic [1:0] {
    ACT_ALLOC = 2'd0,
    ACT_FREE  = 2'd1,
    ACT_QUERY = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOSPACE  = 2'd1,
    ST_NOTBLOCK = 2'd2
  } status_t;

  typedef struct packed {
    logic [1:0]       action;
    logic [PTR_W-1:0] request_words;
    logic [PTR_W-1:0] block_pointer;
  } req_t;

  typedef struct packed {
    logic [PTR_W-1:0] pointer_out;
    logic [PTR_W-1:0] payload_words;
    logic [1:0]       status;
  } rsp_t;

endpackage

@@ rtl/first_fit_heap_allocator_unit.sv @@
`timescale 1ns / 1ps
// first_fit_heap_allocator_unit: header-walking first-fit heap allocator
// depends on ffh_pkg and ffh_ram
//
//   channel  valid      stall      payload  role
//   request  req_valid  req_stall  req      action, request_words, block_pointer
//   response rsp_valid  rsp_stall  rsp      pointer_out, payload_words, status
//
// after reset a clearing pass writes every heap entry,
// with req_stall high throughout
// allocate walks the headers and, on a split, merges the remainder;
// free merges with neighbours, size query reads one header; one item at a time
// the cost is set by the single heap entry ram, one read and one write a cycle
// a result waits in the response register while the next item is accepted
module first_fit_heap_allocator_unit
  import ffh_pkg::*;
#(
  parameter int HEAP_CAPACITY = 1024,
  parameter int INITIAL_WORDS = 256
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  localparam int AW   = $clog2(HEAP_CAPACITY);
  localparam int LW   = $clog2(HEAP_CAPACITY + 1);
  localparam int EW   = ((LW > PTR_W) ? LW : PTR_W) + 2;
  localparam int INIT = (INITIAL_WORDS > HEAP_CAPACITY) ? HEAP_CAPACITY : INITIAL_WORDS;
  localparam int DW   = 2 + LW + AW;

  typedef struct packed {
    logic          hdr;
    logic          alloc;
    logic [LW-1:0] len;
    logic [AW-1:0] prev;
  } entry_t;

  typedef enum logic [15:0] {
    S_IDLE    = 16'h0001,
    S_CLEAR   = 16'h0002,
    S_WALK_RD = 16'h0004,
    S_WALK_EV = 16'h0008,
    S_APPEND  = 16'h0010,
    S_LOOK_RD = 16'h0020,
    S_LOOK_EV = 16'h0040,
    S_M1      = 16'h0080,
    S_M2      = 16'h0100,
    S_M3      = 16'h0200,
    S_M3B     = 16'h0400,
    S_M4      = 16'h0800,
    S_M5      = 16'h1000,
    S_M6      = 16'h2000,
    S_M8      = 16'h4000,
    S_DONE    = 16'h8000
  } state_t;

  state_t           state;
  logic [AW-1:0]    clr;
  logic [LW-1:0]    heap_top;
  logic [LW-1:0]    i;
  logic [AW-1:0]    last;
  logic [AW-1:0]    hdr;
  logic [LW-1:0]    h_len;
  logic [AW-1:0]    h_prev;
  logic [1:0]       act;
  logic [PTR_W-1:0] sz;
  logic             bp_bad;
  logic [PTR_W-1:0] r_ptr;
  logic [PTR_W-1:0] r_words;
  status_t          r_status;

  logic          we;
  logic [AW-1:0] waddr;
  entry_t        wdata;
  logic [AW-1:0] raddr;
  logic [DW-1:0] rdata_raw;
  entry_t        rd;

  logic [EW-1:0] top_e, nxt_e, len_e, size_e, i_e;
  logic          nxt_in, pred_ok, fits, is_eq, is_big;

  ffh_ram #(.WIDTH(DW), .DEPTH(HEAP_CAPACITY)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata_raw)
  );

  assign rd      = entry_t'(rdata_raw);
  assign top_e   = EW'(heap_top);
  assign nxt_e   = EW'(hdr) + EW'(h_len) + EW'(1);
  assign len_e   = EW'(rd.len);
  assign size_e  = EW'(sz);
  assign i_e     = EW'(i);
  assign nxt_in  = nxt_e < top_e;
  assign pred_ok = (h_prev != '0) && (EW'(h_prev) < top_e);
  assign fits    = !((i_e + size_e + EW'(1) > EW'(HEAP_CAPACITY)) ||
                     (i_e + EW'(1) >= EW'(PTR_LIMIT)));
  assign is_eq   = !rd.alloc && (len_e == size_e);
  assign is_big  = !rd.alloc && (len_e > size_e);

  assign req_stall = (state != S_IDLE);

  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    raddr = '0;
    unique case (state) inside
      S_CLEAR: begin
        we    = 1'b1;
        waddr = clr;
        if (clr == AW'(1)) begin
          wdata = {1'b1, 1'b0, LW'(INIT - 2), AW'(0)};
        end
      end
      S_WALK_RD: raddr = AW'(i);
      S_WALK_EV: begin
        waddr = AW'(i);
        if (is_eq) begin
          we    = 1'b1;
          wdata = {rd.hdr, 1'b1, rd.len, rd.prev};
        end else if (is_big) begin
          we    = 1'b1;
          wdata = {1'b1, 1'b1, LW'(sz), rd.prev};
        end
      end
      S_APPEND: begin
        we    = fits;
        waddr = AW'(i);
        wdata = {1'b1, 1'b1, LW'(sz), last};
      end
      S_LOOK_RD: raddr = hdr;
      S_M1, S_M3: raddr = AW'(nxt_e);
      S_M2: begin
        we    = 1'b1;
        waddr = AW'(nxt_e);
        wdata = rd.alloc ? {rd.hdr, rd.alloc, rd.len, hdr} : {2'b00, rd.len, rd.prev};
      end
      S_M3B: begin
        we    = 1'b1;
        waddr = AW'(nxt_e);
        wdata = {rd.hdr, rd.alloc, rd.len, hdr};
      end
      S_M4: begin
        raddr = h_prev;
        we    = !pred_ok;
        waddr = hdr;
        wdata = {1'b1, 1'b0, h_len, h_prev};
      end
      S_M5: begin
        we = 1'b1;
        if (!rd.alloc) begin
          waddr = h_prev;
          wdata = {rd.hdr, 1'b0, rd.len + h_len + LW'(1), rd.prev};
        end else begin
          waddr = hdr;
          wdata = {1'b1, 1'b0, h_len, h_prev};
        end
      end
      S_M6: begin
        we    = 1'b1;
        waddr = hdr;
        wdata = {2'b00, h_len, h_prev};
        raddr = AW'(nxt_e);
      end
      S_M8: begin
        we    = 1'b1;
        waddr = AW'(nxt_e);
        wdata = {rd.hdr, rd.alloc, rd.len, h_prev};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr       <= '0;
      heap_top  <= LW'(INIT);
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall && state != S_DONE) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr <= clr + AW'(1);
          if (clr == AW'(HEAP_CAPACITY - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req_valid) begin
            act      <= req.action;
            sz       <= req.request_words;
            hdr      <= AW'(EW'(req.block_pointer) - EW'(1));
            bp_bad   <= (req.block_pointer == '0) ||
                        (EW'(req.block_pointer) - EW'(1) >= top_e);
            i        <= LW'(1);
            last     <= '0;
            r_ptr    <= '0;
            r_words  <= '0;
            r_status <= ST_OK;
            unique case (req.action) inside
              ACT_ALLOC:           state <= S_WALK_RD;
              ACT_FREE, ACT_QUERY: state <= S_LOOK_RD;
              default:             state <= S_DONE;
            endcase
          end
        end
        S_WALK_RD: state <= (i_e < top_e) ? S_WALK_EV : S_APPEND;
        S_WALK_EV: begin
          last <= AW'(i);
          if (is_eq) begin
            r_ptr <= PTR_W'(i_e + EW'(1));
            state <= S_DONE;
          end else if (is_big) begin
            hdr    <= AW'(i_e + size_e + EW'(1));
            h_len  <= LW'(len_e - size_e - EW'(1));
            h_prev <= AW'(i);
            r_ptr  <= PTR_W'(i_e + EW'(1));
            state  <= S_M1;
          end else begin
            i     <= LW'(i_e + len_e + EW'(1));
            state <= S_WALK_RD;
          end
        end
        S_APPEND: begin
          if (fits) begin
            heap_top <= LW'(i_e + size_e + EW'(1));
            r_ptr    <= PTR_W'(i_e + EW'(1));
          end else begin
            r_status <= ST_NOSPACE;
          end
          state <= S_DONE;
        end
        S_LOOK_RD: state <= S_LOOK_EV;
        S_LOOK_EV: begin
          if (bp_bad || !rd.hdr) begin
            r_status <= ST_NOTBLOCK;
            state    <= S_DONE;
          end else if (act == ACT_QUERY) begin
            r_words <= PTR_W'(rd.len);
            state   <= S_DONE;
          end else begin
            h_len  <= rd.len;
            h_prev <= rd.prev;
            state  <= S_M1;
          end
        end
        S_M1: state <= nxt_in ? S_M2 : S_M4;
        S_M2: begin
          if (!rd.alloc) begin
            h_len <= h_len + rd.len + LW'(1);
            state <= S_M3;
          end else begin
            state <= S_M4;
          end
        end
        S_M3:  state <= nxt_in ? S_M3B : S_M4;
        S_M3B: state <= S_M4;
        S_M4:  state <= pred_ok ? S_M5 : S_DONE;
        S_M5:  state <= !rd.alloc ? S_M6 : S_DONE;
        S_M6:  state <= nxt_in ? S_M8 : S_DONE;
        S_M8:  state <= S_DONE;
        S_DONE: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp_valid         <= 1'b1;
            rsp.pointer_out   <= r_ptr;
            rsp.payload_words <= r_words;
            rsp.status        <= r_status;
            state             <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_top_grows: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> heap_top >= $past(heap_top))
    else $error("heap top shrank");

  a_top_bound: assert property (@(posedge clk) disable iff (rst)
    EW'(heap_top) <= EW'(HEAP_CAPACITY))
    else $error("heap top beyond capacity");

  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !we)
    else $error("heap write while idle");

endmodule

@@ rtl/ffh_ram.sv @@
`timescale 1ns / 1ps
// ffh_ram: generic simple dual-port ram, one write and one registered read port
// depends on nothing
module ffh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sim/tb_first_fit_heap_allocator_unit.sv @@
`timescale 1ns / 1ps
// tb_first_fit_heap_allocator_unit: self-checking bench for the first-fit heap allocator
// drives directed and random allocate/free/query items and checks against a heap model
// depends on ffh_pkg and first_fit_heap_allocator_unit
module tb_first_fit_heap_allocator_unit
  import ffh_pkg::*;
;

  localparam int CAP = 1024;
  localparam int INIT = 256;
  localparam int CYCLE_LIMIT = 20000000;

  class heap_scoreboard;
    bit          hdr[CAP];
    bit          used[CAP];
    int unsigned len[CAP];
    int unsigned prv[CAP];
    int unsigned top;
    rsp_t        pending[$];
    int          errors;

    function void clear();
      foreach (hdr[i]) begin
        hdr[i] = 0;
        used[i] = 0;
        len[i] = 0;
        prv[i] = 0;
      end
      hdr[1] = 1;
      len[1] = INIT - 2;
      top = INIT;
      errors = 0;
    endfunction

    function void coalesce(int unsigned h);
      int unsigned nx;
      int unsigned p;
      nx = h + len[h] + 1;
      if (nx < top && !used[nx]) begin
        len[h] += len[nx] + 1;
        hdr[nx] = 0;
        used[nx] = 0;
        nx = h + len[h] + 1;
        if (nx < top) prv[nx] = h;
      end
      p = prv[h];
      if (p != 0 && p < top && !used[p]) begin
        len[p] += 1 + len[h];
        nx = h + len[h] + 1;
        if (nx < top) prv[nx] = p;
        hdr[h] = 0;
        used[h] = 0;
      end
    endfunction

    function int unsigned allocate(int unsigned sz, output status_t st);
      int unsigned i;
      int unsigned last;
      int unsigned rem;
      int unsigned rl;
      i = 1;
      last = 0;
      st = ST_OK;
      while (i < top) begin
        last = i;
        if (!used[i]) begin
          if (len[i] == sz) begin
            used[i] = 1;
            return i + 1;
          end
          if (len[i] > sz) begin
            rem = i + sz + 1;
            rl = len[i] - sz - 1;
            len[i] = sz;
            used[i] = 1;
            hdr[rem] = 1;
            used[rem] = 0;
            len[rem] = rl;
            prv[rem] = i;
            if (rem + rl + 1 < top) prv[rem + rl + 1] = rem;
            coalesce(rem);
            return i + 1;
          end
        end
        i += len[i] + 1;
      end
      if (i + sz + 1 > CAP || i + 1 >= PTR_LIMIT) begin
        st = ST_NOSPACE;
        return 0;
      end
      hdr[i] = 1;
      used[i] = 1;
      len[i] = sz;
      prv[i] = last;
      top = i + sz + 1;
      return i + 1;
    endfunction

    function bit starts_block(int unsigned p);
      return p != 0 && p - 1 < top && hdr[p - 1];
    endfunction

    function void note_request(req_t r);
      rsp_t e;
      status_t st;
      e = '0;
      st = ST_OK;
      case (r.action)
        ACT_ALLOC: e.pointer_out = PTR_W'(allocate(r.request_words, st));
        ACT_FREE: begin
          if (starts_block(r.block_pointer)) begin
            used[r.block_pointer - 1] = 0;
            coalesce(r.block_pointer - 1);
          end else st = ST_NOTBLOCK;
        end
        ACT_QUERY: begin
          if (starts_block(r.block_pointer))
            e.payload_words = PTR_W'(len[r.block_pointer - 1]);
          else st = ST_NOTBLOCK;
        end
        default: ;
      endcase
      e.status = st;
      pending.push_back(e);
    endfunction

    function void check_result(rsp_t a);
      rsp_t e;
      if (pending.size() == 0) begin
        $error("unexpected result %h", a);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (a.pointer_out !== e.pointer_out) begin
        $error("pointer_out expected %0d actual %0d", e.pointer_out, a.pointer_out);
        errors++;
      end
      if (a.payload_words !== e.payload_words) begin
        $error("payload_words expected %0d actual %0d", e.payload_words, a.payload_words);
        errors++;
      end
      if (a.status !== e.status) begin
        $error("status expected %0d actual %0d", e.status, a.status);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic req_valid = 0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 0;
  rsp_t rsp;

  heap_scoreboard sb;
  int idle_pct = 0;
  int stall_pct = 0;
  int cycles = 0;
  int unsigned live_ptrs[$];

  first_fit_heap_allocator_unit uut (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_first_fit_heap_allocator_unit: FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) sb.check_result(rsp);
    rsp_stall <= !rst && ($urandom_range(99) < stall_pct);
  end

  task automatic send_item(input req_t r);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      req_valid <= 0;
      @(posedge clk);
    end
    req_valid <= 1;
    req <= r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    sb.note_request(r);
  endtask

  task automatic send_op(input action_t a, input int unsigned sz, input int unsigned p);
    req_t r;
    r.action = a;
    r.request_words = PTR_W'(sz);
    r.block_pointer = PTR_W'(p);
    send_item(r);
    if (a == ACT_ALLOC && sb.pending[$].pointer_out != 0)
      live_ptrs.push_back(sb.pending[$].pointer_out);
  endtask

  task automatic drain();
    req_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  task automatic random_item();
    int k;
    int unsigned idx;
    int unsigned p;
    req_t r;
    k = $urandom_range(99);
    if (k < 40) begin
      if ($urandom_range(19) == 0) send_op(ACT_ALLOC, $urandom_range(1023), 0);
      else send_op(ACT_ALLOC, $urandom_range(40), $urandom_range(1023));
    end else if (k < 70 && live_ptrs.size() > 0) begin
      idx = $urandom_range(live_ptrs.size() - 1);
      p = live_ptrs[idx];
      live_ptrs.delete(idx);
      send_op(ACT_FREE, $urandom_range(1023), p);
    end else if (k < 88 && live_ptrs.size() > 0) begin
      p = live_ptrs[$urandom_range(live_ptrs.size() - 1)];
      send_op(ACT_QUERY, $urandom_range(1023), p);
    end else begin
      r.action = 2'($urandom);
      r.request_words = PTR_W'($urandom);
      r.block_pointer = PTR_W'($urandom);
      send_item(r);
    end
  endtask

  initial begin
    sb = new();
    sb.clear();
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    send_op(ACT_QUERY, 0, 2);
    send_op(ACT_QUERY, 0, 0);
    send_op(ACT_FREE, 0, 0);
    send_op(ACT_FREE, 0, 1023);
    send_op(ACT_QUERY, 0, 5);
    send_op(ACT_ALLOC, 0, 0);
    send_op(ACT_ALLOC, 10, 0);
    send_op(ACT_ALLOC, 252, 0);
    send_op(ACT_ALLOC, 1023, 0);
    send_op(ACT_ALLOC, 1022, 0);
    send_op(ACT_ALLOC, 700, 0);
    send_op(ACT_QUERY, 0, 4);
    send_op(ACT_FREE, 0, 4);
    send_op(ACT_FREE, 0, 4);
    send_op(ACT_QUERY, 0, 4);
    send_op(ACT_FREE, 0, 2);
    send_op(ACT_FREE, 0, 3);
    send_op(ACT_ALLOC, 5, 0);
    send_item({2'd3, 10'h3ff, 10'h3ff});
    send_item({2'd3, 10'h000, 10'h000});
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin idle_pct = 0; stall_pct = 0; end
        1: begin idle_pct = 84; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 84; end
        3: begin idle_pct = 35; stall_pct = 35; end
        default: begin idle_pct = 0; stall_pct = 0; end
      endcase
      for (int n = 0; n < 240; n++) begin
        random_item();
        if (n == 120) drain();
      end
    end

    idle_pct = 0;
    stall_pct = 0;
    drain();
    repeat (100) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("tb_first_fit_heap_allocator_unit: PASS");
    else
      $display("tb_first_fit_heap_allocator_unit: FAIL");
    $finish;
  end
endmodule
